/* rtl/imm_pkg.sv */
// Shared widths, codes and types of the integer matrix multiply core.
`timescale 1ns / 1ps

package imm_pkg;

	localparam int MAX_DIM     = 64;
	localparam int IDX_W       = $clog2(MAX_DIM);
	localparam int ADDR_W      = 2 * IDX_W;
	localparam int DIM_W       = 7;
	localparam int VAL_W       = 16;
	localparam int MUL_W       = 2 * VAL_W;
	localparam int PROD_W      = 38;
	localparam int FUNC_W      = 2;
	localparam int S_TDATA_W   = 32;
	localparam int M_TDATA_W   = 40;
	localparam int S_FIELDS_W  = 2 * IDX_W + VAL_W;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_WR_A = 2'd0,
		FUNC_WR_B = 2'd1,
		FUNC_RD   = 2'd2,
		FUNC_NOP  = 2'd3
	} func_t;

endpackage

/* rtl/integer_matrix_multiply_core.sv */
// Integer matrix multiply core: element stores for A and B and a multiply-accumulate engine.
`timescale 1ns / 1ps

// Each input transfer on s_axis writes one element of A or B, asks for one
// element of C = A x B, or does nothing (FUNC_NOP). tuser carries the
// function code; tdata carries the row, column and element value. Every
// input transfer gives exactly one output transfer on m_axis: the 38-bit
// dot product in tdata (zero for writes, no-ops and index errors) and the index error flag in tuser.
// A write is stored at the edge that accepts it and its result passes
// through ST_DONE into the output register. A product read walks dim
// multiply-accumulate steps (a dim above 64 counts as 64), one element
// pair a cycle from the two element memories, and its result passes
// through ST_DRAIN and ST_DONE into the output register. One item is worked
// on at a time. The size register cfg_wdata may be written only while the block is idle.
// Reset clears the control state and sets the size to 64; the element stores
// are not cleared and must be written before use. When the receiver stalls,
// the result is held in the output register and the next input transfer is
// still taken; the block then waits before presenting the following result.
module integer_matrix_multiply_core
	import imm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [DIM_W-1:0]     cfg_wdata,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [S_TDATA_W-1:0] s_axis_tdata,   // row [5:0], col [11:6], value [27:12]
	input  logic [FUNC_W-1:0]    s_axis_tuser,   // func [1:0]
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [M_TDATA_W-1:0] m_axis_tdata,   // product [37:0]
	output logic                 m_axis_tuser    // index_error [0]
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_RUN   = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

	state_t state_q;

	logic [DIM_W-1:0] dim_q;
	logic [DIM_W-1:0] n_sat;
	logic [IDX_W-1:0] last_k;

	logic                    in_acc;
	func_t                   in_func;
	logic [IDX_W-1:0]        in_row;
	logic [IDX_W-1:0]        in_col;
	logic signed [VAL_W-1:0] in_value;
	logic                    idx_err;

	logic [IDX_W-1:0] row_q;
	logic [IDX_W-1:0] col_q;
	logic [IDX_W-1:0] k_q;
	logic             res_err_q;
	logic             res_rd_q;

	logic signed [VAL_W-1:0] mem_a [0:MAX_DIM*MAX_DIM-1];
	logic signed [VAL_W-1:0] mem_b [0:MAX_DIM*MAX_DIM-1];
	logic                    we_a;
	logic                    we_b;
	logic [ADDR_W-1:0]       waddr;
	logic [ADDR_W-1:0]       raddr_a;
	logic [ADDR_W-1:0]       raddr_b;

	logic                    issue;
	logic                    issue_last;
	logic signed [VAL_W-1:0] a_rd_s1;
	logic signed [VAL_W-1:0] b_rd_s1;
	logic                    v_s1;
	logic                    last_s1;
	logic signed [MUL_W-1:0] prod_s2;
	logic                    v_s2;
	logic                    last_s2;
	logic signed [PROD_W-1:0] acc_q;

	logic                 out_free;
	logic                 m_valid_q;
	logic [PROD_W-1:0]    m_prod_q;
	logic                 m_err_q;

	assign n_sat  = (dim_q > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : dim_q;
	assign last_k = IDX_W'(n_sat - DIM_W'(1));

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign in_func       = func_t'(s_axis_tuser);
	assign in_row        = s_axis_tdata[IDX_W-1:0];
	assign in_col        = s_axis_tdata[2*IDX_W-1:IDX_W];
	assign in_value      = s_axis_tdata[S_FIELDS_W-1:2*IDX_W];
	assign idx_err       = (DIM_W'(in_row) >= n_sat) || (DIM_W'(in_col) >= n_sat);

	assign we_a    = in_acc && (in_func == FUNC_WR_A) && !idx_err;
	assign we_b    = in_acc && (in_func == FUNC_WR_B) && !idx_err;
	assign waddr   = {in_row, in_col};
	assign raddr_a = {row_q, k_q};
	assign raddr_b = {k_q, col_q};

	assign issue      = (state_q == ST_RUN);
	assign issue_last = (k_q == last_k);

	always_ff @(posedge clk) begin
		if (we_a) begin
			mem_a[waddr] <= in_value;
		end
		a_rd_s1 <= mem_a[raddr_a];
	end

	always_ff @(posedge clk) begin
		if (we_b) begin
			mem_b[waddr] <= in_value;
		end
		b_rd_s1 <= mem_b[raddr_b];
	end

	always_ff @(posedge clk) begin
		prod_s2 <= a_rd_s1 * b_rd_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_q <= DIM_W'(MAX_DIM);
		end else if (cfg_we) begin
			dim_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			last_s1 <= 1'b0;
			v_s2    <= 1'b0;
			last_s2 <= 1'b0;
		end else begin
			v_s1    <= issue;
			last_s1 <= issue && issue_last;
			v_s2    <= v_s1;
			last_s2 <= last_s1;
		end
	end

	assign out_free = !m_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			k_q       <= '0;
			row_q     <= '0;
			col_q     <= '0;
			res_err_q <= 1'b0;
			res_rd_q  <= 1'b0;
			acc_q     <= '0;
			m_valid_q <= 1'b0;
			m_prod_q  <= '0;
			m_err_q   <= 1'b0;
		end else begin
			if (m_valid_q && m_axis_tready && (state_q != ST_DONE)) begin
				m_valid_q <= 1'b0;
			end
			if (v_s2) begin
				acc_q <= acc_q + PROD_W'(prod_s2);
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						row_q     <= in_row;
						col_q     <= in_col;
						k_q       <= '0;
						acc_q     <= '0;
						res_err_q <= (in_func != FUNC_NOP) && idx_err;
						res_rd_q  <= (in_func == FUNC_RD) && !idx_err;
						if ((in_func == FUNC_RD) && !idx_err) begin
							state_q <= ST_RUN;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_RUN: begin
					k_q <= k_q + IDX_W'(1);
					if (issue_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (v_s2 && last_s2) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						m_valid_q <= 1'b1;
						m_prod_q  <= res_rd_q ? acc_q : '0;
						m_err_q   <= res_err_q;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {(M_TDATA_W-PROD_W)'(0), m_prod_q};
	assign m_axis_tuser  = m_err_q;

endmodule

/* rtl/imm_checker.sv */
// Port-level checks for the integer matrix multiply core, bound to the top level.
`timescale 1ns / 1ps

module imm_checker
	import imm_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_axis_tvalid,
	input logic                 s_axis_tready,
	input logic                 m_axis_tvalid,
	input logic                 m_axis_tready,
	input logic [M_TDATA_W-1:0] m_axis_tdata,
	input logic                 m_axis_tuser
);

	logic s_xfer;

	assign s_xfer = s_axis_tvalid && s_axis_tready;

	// An accepted item occupies the engine, so no second item follows at once.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_xfer |=> !s_axis_tready)
		else $error("input accepted on two consecutive cycles");

	// An index error always comes with a zero product.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
		else $error("index error with non-zero product");

	// The padding bits above the product are always zero.
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[M_TDATA_W-1:PROD_W] == '0))
		else $error("output padding bits not zero");

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
		else $error("output valid dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> ($stable(m_axis_tdata) && $stable(m_axis_tuser)))
		else $error("output changed while stalled");

endmodule

bind integer_matrix_multiply_core imm_checker u_imm_checker (.*);
